// ----- hdl/wbps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern search.
// No dependencies; every other file of the block but wbps_stream_if imports this package.
package wbps_pkg;

	// Sizes
	localparam int DEF_MAX_PATTERN = 256;
	localparam int MIN_LENGTH      = 3;
	localparam int BYTE_W          = 8;
	localparam int IDX_W           = 8;
	localparam int PLEN_W          = 9;
	localparam int ADDR_W          = 64;
	localparam int OFFSET_W        = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 64;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SCAN = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

	// Request beat
	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  pattern_index;
		logic [BYTE_W-1:0] pattern_byte;
		logic              care;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} req_t;

	// Result beat
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
		logic [PLEN_W-1:0] match_length;
	} res_t;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic              scan;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] load_byte;
		logic              load_care;
	} cell_ctl_t;

	// Scan byte held behind the cell row
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [OFFSET_W-1:0] start;
	} scan_stage_t;

endpackage

// ----- hdl/wbps_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat.
// Payload type is given at instantiation; no other dependencies.
interface wbps_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wbps_cell.sv -----
`timescale 1ns / 1ps
// One pattern position: expected byte, care bit and its match-vector bit.
// Depends on wbps_pkg.
module wbps_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  wbps_pkg::cell_ctl_t ctl,
	input  logic              sel,
	input  logic              en,
	input  logic              prev,
	output logic              match
);
	import wbps_pkg::*;

	logic [BYTE_W-1:0] pat_q;
	logic              care_q;
	logic              match_q;
	logic              pos_ok;

	// pattern position store, written by a load beat
	always_ff @(posedge clk) begin
		if (sel) begin
			pat_q  <= ctl.load_byte;
			care_q <= ctl.load_care;
		end
	end

	assign pos_ok = !care_q || (pat_q == ctl.data_byte);

	// shift-and step: extend the neighbour's partial match by this position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.scan) begin
			match_q <= en & prev & pos_ok;
		end
	end

	assign match = match_q;
endmodule

// ----- hdl/wbps_report.sv -----
`timescale 1ns / 1ps
// Result stage: first-hit tracking per region and the result register.
// Depends on wbps_pkg and wbps_stream_if.
module wbps_report (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wbps_pkg::scan_stage_t        stage,
	input  logic                         hit,
	input  logic [wbps_pkg::ADDR_W-1:0]  base,
	input  logic [wbps_pkg::PLEN_W-1:0]  len,
	output logic                         go,
	wbps_stream_if.source                res
);
	import wbps_pkg::*;

	logic done_q;
	logic out_valid_q;
	res_t out_q;
	logic produce;

	// a beat is due on the first hit, or at region end with no hit so far
	assign produce = stage.valid && !done_q && (hit || stage.last);
	assign go      = !produce || !out_valid_q || res.ready;

	// region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (stage.valid && go) begin
			if (stage.last) begin
				done_q <= 1'b0;
			end else if (hit) begin
				done_q <= 1'b1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce && go) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (produce && go) begin
			out_q.found         <= hit;
			out_q.match_address <= hit ? base + {{(ADDR_W-OFFSET_W){1'b0}}, stage.start}
			                           : '0;
			out_q.match_length  <= hit ? len : '0;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;
endmodule

// ----- hdl/wildcard_byte_pattern_search.sv -----
`timescale 1ns / 1ps
// Wildcard byte pattern search. Load beats (req_type 0) write one pattern
// position; scan beats (req_type 1) stream a region one byte per cycle
// unless stalled, and the beat with last_byte set closes the region. One result
// per region: the first full match (start address = base_address + offset) or
// found=0 at the region end. Throughput is one beat per clock unless the input
// stalls; each cell of the row compares its position against the byte and hands
// its match bit on. The edge that accepts the deciding byte loads the cell row
// and the scan stage, and the output register is loaded from them once the
// result stage can take the beat. A result held in the output register stalls
// the input only when a second result is due behind it.
// Depends on wbps_pkg, wbps_stream_if, wbps_cell and wbps_report.
module wildcard_byte_pattern_search #(
	parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN
) (
	input  logic                               clk,
	input  logic                               arst_n,
	wbps_stream_if.sink                        req,
	wbps_stream_if.source                      res,
	input  logic                               cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import wbps_pkg::*;

	localparam int LEN_RAW_W = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W     = (LEN_RAW_W > PLEN_W) ? LEN_RAW_W : PLEN_W;

	logic [ADDR_W-1:0]      base_q;
	logic [PLEN_W-1:0]      plen_q;
	logic [LEN_W-1:0]       plen_ext;
	logic [LEN_W-1:0]       len_eff;
	logic [OFFSET_W-1:0]    offset_q;
	logic                   fresh_q;
	scan_stage_t            stage_s1;
	logic                   accept;
	logic                   scan_acc;
	logic                   load_acc;
	logic                   go;
	logic                   hit;
	cell_ctl_t              ctl;
	logic [MAX_PATTERN-1:0] match_vec;
	logic [MAX_PATTERN-1:0] term_vec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			plen_q <= PLEN_W'(MIN_LENGTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE_ADDRESS:   base_q <= cfg_wdata[ADDR_W-1:0];
				CFG_PATTERN_LENGTH: plen_q <= cfg_wdata[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// length in use, clamped between MIN_LENGTH and the cell row
	assign plen_ext = LEN_W'(plen_q);
	always_comb begin
		if (plen_ext < LEN_W'(MIN_LENGTH)) begin
			len_eff = LEN_W'(MIN_LENGTH);
		end else if (plen_ext > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = plen_ext;
		end
	end

	// handshake
	assign req.ready = !stage_s1.valid || go;
	assign accept    = req.valid && req.ready;
	assign scan_acc  = accept && (req.data.req_type == REQ_SCAN);
	assign load_acc  = accept && (req.data.req_type == REQ_LOAD);

	// region byte counter, saturating; fresh marks the start of a new region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			fresh_q  <= 1'b0;
		end else if (scan_acc) begin
			fresh_q <= req.data.last_byte;
			if (req.data.last_byte) begin
				offset_q <= '0;
			end else if (offset_q != '1) begin
				offset_q <= offset_q + OFFSET_W'(1);
			end
		end
	end

	// scan stage behind the cell row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (scan_acc) begin
			stage_s1.valid <= 1'b1;
			stage_s1.last  <= req.data.last_byte;
			stage_s1.start <= offset_q - OFFSET_W'(len_eff - LEN_W'(1));
		end else if (go) begin
			stage_s1.valid <= 1'b0;
		end
	end

	// broadcast to the cells
	assign ctl.scan      = scan_acc;
	assign ctl.data_byte = req.data.data_byte;
	assign ctl.load_byte = req.data.pattern_byte;
	assign ctl.load_care = req.data.care;

	// cell row
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic sel;
		logic prev;
		logic en;

		if (i < (1 << IDX_W)) begin : g_sel
			assign sel = load_acc && (req.data.pattern_index == IDX_W'(i));
		end else begin : g_nosel
			assign sel = 1'b0;
		end

		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = match_vec[i-1] && !fresh_q;
		end

		assign en          = LEN_W'(i) < len_eff;
		assign term_vec[i] = LEN_W'(i) == (len_eff - LEN_W'(1));

		wbps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (sel),
			.en     (en),
			.prev   (prev),
			.match  (match_vec[i])
		);
	end

	// full match at the last position in use
	assign hit = |(match_vec & term_vec);

	wbps_report u_report (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage_s1),
		.hit    (hit),
		.base   (base_q),
		.len    (len_eff[PLEN_W-1:0]),
		.go     (go),
		.res    (res)
	);
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for wildcard_byte_pattern_search: random and directed load and scan
// beats, with a scoreboard class that predicts the search results. Depends on wbps_pkg,
// wbps_stream_if and the top level of the block.
module tb;
	import wbps_pkg::*;

	// Predicts search results from accepted beats and checks the result stream
	class search_scoreboard;
		bit [BYTE_W-1:0]          pat_byte [DEF_MAX_PATTERN];
		bit                       pat_care [DEF_MAX_PATTERN];
		bit [DEF_MAX_PATTERN-1:0] match_vec;
		bit [OFFSET_W-1:0]        offset;
		bit                       region_hit;
		bit [ADDR_W-1:0]          base;
		bit [PLEN_W-1:0]          plen = PLEN_W'(MIN_LENGTH);
		res_t                     due_results [$];
		int                       mismatches;
		int                       matches_seen;
		int                       misses_seen;

		// Pattern length after clamping to the legal span
		function int unsigned span();
			if (plen < MIN_LENGTH)
				return MIN_LENGTH;
			if (plen > DEF_MAX_PATTERN)
				return DEF_MAX_PATTERN;
			return plen;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_BASE_ADDRESS)
				base = value;
			else if (idx == CFG_PATTERN_LENGTH)
				plen = value[PLEN_W-1:0];
		endfunction

		// Advance the search by one accepted request beat
		function void note_request(input req_t r);
			bit [DEF_MAX_PATTERN-1:0] ok;
			bit [DEF_MAX_PATTERN-1:0] in_use;
			int unsigned              len;
			res_t                     exp_res;
			if (r.req_type == REQ_LOAD) begin
				pat_byte[r.pattern_index] = r.pattern_byte;
				pat_care[r.pattern_index] = r.care;
				return;
			end
			len = span();
			if (!region_hit) begin
				for (int i = 0; i < DEF_MAX_PATTERN; i++) begin
					ok[i]     = !pat_care[i] || pat_byte[i] == r.data_byte;
					in_use[i] = i < len;
				end
				// shift-and: position 0 may start on any byte
				match_vec = {match_vec[DEF_MAX_PATTERN-2:0], 1'b1} & ok & in_use;
				if (match_vec[len-1]) begin
					region_hit            = 1'b1;
					exp_res.found         = 1'b1;
					exp_res.match_address = base + ADDR_W'(offset) - ADDR_W'(len - 1);
					exp_res.match_length  = PLEN_W'(len);
					due_results.push_back(exp_res);
				end
			end
			if (offset != '1)
				offset++;
			// region end: report a miss unless a match was already given
			if (r.last_byte) begin
				if (!region_hit) begin
					exp_res = '0;
					due_results.push_back(exp_res);
				end
				match_vec  = '0;
				offset     = '0;
				region_hit = 1'b0;
			end
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result found=%0b address=%h length=%0d",
						$time, got.found, got.match_address, got.match_length);
				return;
			end
			want = due_results.pop_front();
			if (got.found === 1'b1)
				matches_seen++;
			else
				misses_seen++;
			if (got.found !== want.found || got.match_address !== want.match_address ||
					got.match_length !== want.match_length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch, expected found=%0b address=%h length=%0d, %s",
						$time, want.found, want.match_address, want.match_length,
						$sformatf("got found=%0b address=%h length=%0d",
							got.found, got.match_address, got.match_length));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wbps_stream_if #(.payload_t(req_t)) req_ch ();
	wbps_stream_if #(.payload_t(res_t)) res_ch ();

	search_scoreboard sb = new();

	bit          calm;
	int unsigned hold_request;
	int unsigned beats_sent;
	int unsigned regions_sent;

	wildcard_byte_pattern_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Offer one beat, with an occasional idle burst first
	task automatic send_beat(input req_t b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= b;
		forever begin
			@(posedge clk);
			if (req_ch.ready === 1'b1)
				break;
		end
		sb.note_request(b);
		beats_sent++;
	endtask

	task automatic load_beat(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] pbyte,
			input logic care);
		req_t b;
		b.req_type      = REQ_LOAD;
		b.pattern_index = idx;
		b.pattern_byte  = pbyte;
		b.care          = care;
		b.data_byte     = BYTE_W'($urandom);
		b.last_byte     = 1'($urandom);
		send_beat(b);
	endtask

	task automatic scan_beat(input logic [BYTE_W-1:0] data, input logic last);
		req_t b;
		b.req_type      = REQ_SCAN;
		b.pattern_index = IDX_W'($urandom);
		b.pattern_byte  = BYTE_W'($urandom);
		b.care          = 1'($urandom);
		b.data_byte     = data;
		b.last_byte     = last;
		send_beat(b);
	endtask

	// One region; bytes lean towards pattern bytes so partial matches are common.
	// With plant set and room for it, a pattern instance is laid in, at the end when tail is set.
	task automatic scan_region(input int unsigned nbytes, input bit plant, input bit tail);
		bit [BYTE_W-1:0] bytes [$];
		int unsigned     len;
		int unsigned     s;
		len = sb.span();
		for (int i = 0; i < nbytes; i++)
			bytes.push_back($urandom_range(0, 1) ? BYTE_W'($urandom)
				: sb.pat_byte[$urandom_range(0, len - 1)]);
		if (plant && nbytes >= len) begin
			s = tail ? nbytes - len : $urandom_range(0, nbytes - len);
			for (int j = 0; j < len; j++)
				if (sb.pat_care[j])
					bytes[s + j] = sb.pat_byte[j];
		end
		for (int i = 0; i < nbytes; i++)
			scan_beat(bytes[i], i == nbytes - 1);
		regions_sent++;
	endtask

	// Stop offering, let every due result arrive and the pipeline empty
	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_registers(input logic [ADDR_W-1:0] base, input int unsigned len);
		logic [CFG_DATA_W-1:0] lenword;
		lenword = {$urandom, 23'($urandom), PLEN_W'(len)};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_wdata <= base;
		@(posedge clk);
		sb.set_register(CFG_BASE_ADDRESS, base);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_wdata <= lenword;
		@(posedge clk);
		sb.set_register(CFG_PATTERN_LENGTH, lenword);
		cfg_we <= 1'b0;
	endtask

	// Result side: check accepted beats, then pick ready for the next cycle
	initial begin
		int unsigned hold_left;
		int unsigned burst_left;
		hold_left  = 0;
		burst_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				sb.check_result(res_ch.data);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(0, 5);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int unsigned small_lens [10] = '{0, 1, 2, 3, 4, 5, 6, 8, 11, 16};
		logic [ADDR_W-1:0] base;
		int unsigned       phase_start;
		int unsigned       len;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_wdata    <= '0;
		arst_n       <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every position that a scan can reach, so none reads an unwritten entry
		for (int i = 0; i < 16; i++)
			load_beat(IDX_W'(i), BYTE_W'($urandom), 1'($urandom));

		// directed: reset settings, pattern 00 ?? FF
		load_beat(IDX_W'(0), 8'h00, 1'b1);
		load_beat(IDX_W'(1), 8'hFF, 1'b0);
		load_beat(IDX_W'(2), 8'hFF, 1'b1);
		scan_beat(8'h00, 1'b0);          // match on the final byte
		scan_beat(8'h5A, 1'b0);
		scan_beat(8'hFF, 1'b1);
		scan_beat(8'hFF, 1'b1);          // region shorter than the pattern
		scan_beat(8'h00, 1'b0);          // match, then bytes that stay silent
		scan_beat(8'h00, 1'b0);
		scan_beat(8'hAA, 1'b0);
		scan_beat(8'hFF, 1'b0);
		scan_beat(8'h00, 1'b1);
		load_beat(IDX_W'(1), 8'h5A, 1'b1); // middle position now checked
		scan_beat(8'h00, 1'b0);          // no match before the region end
		scan_beat(8'h5B, 1'b0);
		scan_beat(8'hFF, 1'b1);
		scan_beat(8'h7F, 1'b0);
		scan_beat(8'h00, 1'b0);
		scan_beat(8'h5A, 1'b0);
		scan_beat(8'hFF, 1'b0);
		scan_beat(8'h11, 1'b0);
		scan_beat(8'h22, 1'b1);

		// random phases with short patterns
		for (int ph = 0; ph < 10; ph++) begin
			drain_and_settle();
			case (ph)
				0: base = '1;
				1: base = '0;
				2: base = 64'hFFFF_FFFF_FFFF_FFF0;
				default: base = {$urandom, $urandom};
			endcase
			write_registers(base, small_lens[ph]);
			calm = (ph % 4 == 3);
			len  = sb.span();
			if (ph == 0) begin
				// long receiver hold while one-byte regions keep coming
				hold_request = 300;
				repeat (30) scan_region(1, 1'b0, 1'b0);
			end
			phase_start = beats_sent;
			while (beats_sent - phase_start < 30) begin
				repeat ($urandom_range(0, 2))
					load_beat($urandom_range(0, 1) ? IDX_W'($urandom_range(0, len - 1))
						: IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom));
				scan_region($urandom_range(1, 2 * len + 6), $urandom_range(0, 3) != 0,
					$urandom_range(0, 3) == 0);
			end
		end

		// full-length pattern, written once exactly and once above the top;
		// short regions keep to the filled positions
		for (int ph = 0; ph < 2; ph++) begin
			drain_and_settle();
			calm = 1'b0;
			write_registers({$urandom, $urandom}, ph == 0 ? 256 : 511);
			scan_region(5, 1'b0, 1'b0);
			scan_region($urandom_range(1, 12), 1'b0, 1'b0);
		end

		// closing stretch with no idling on either side
		drain_and_settle();
		calm = 1'b1;
		write_registers({$urandom, $urandom}, 3);
		phase_start = beats_sent;
		while (beats_sent - phase_start < 30) begin
			load_beat(IDX_W'($urandom_range(0, 2)), BYTE_W'($urandom), 1'($urandom));
			scan_region($urandom_range(1, 8), 1'b1, 1'($urandom));
		end
		drain_and_settle();

		$display("Scanned %0d regions in %0d beats: %0d matches and %0d misses reported",
			regions_sent, beats_sent, sb.matches_seen, sb.misses_seen);
		$display("Lengths from 3 to clamped 256, bases at zero, random and near wrap; %0d errors",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
